### src/sprg_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the stepper pulse ramp generator.
// No dependencies; imported by every module of the block.
package sprg_pkg;

    localparam int STEP_BITS  = 16;
    localparam int DELAY_BITS = 10;
    localparam int CUR_W      = DELAY_BITS + 1;
    localparam int CFG_W      = 8;
    localparam int SUM_W      = ((DELAY_BITS > CFG_W) ? DELAY_BITS : CFG_W) + 1;
    localparam int CFG_IDX_W  = 2;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_OFFSET_MS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETUP_MS       = 2'd3;

    localparam logic [CFG_W-1:0] RST_TICKS_PER_MS   = 8'd20;
    localparam logic [CFG_W-1:0] RST_PULSE_TICKS    = 8'd1;
    localparam logic [CFG_W-1:0] RST_RAMP_OFFSET_MS = 8'd30;
    localparam logic [CFG_W-1:0] RST_SETUP_MS       = 8'd1;

    typedef struct packed {
        logic [CFG_W-1:0] ticks_per_ms;
        logic [CFG_W-1:0] pulse_ticks;
        logic [CFG_W-1:0] ramp_offset_ms;
        logic [CFG_W-1:0] setup_ms;
    } cfg_t;

    typedef struct packed {
        logic                  kind;
        logic [STEP_BITS-1:0]  step_count;
        logic [DELAY_BITS-1:0] target_delay;
        logic                  direction;
    } item_t;

    typedef struct packed {
        logic dir_level;
        logic step_level;
        logic busy_res;
        logic move_done;
        logic start_ignored;
    } result_t;

endpackage

### src/stepper_pulse_ramp_generator_unit.sv
`timescale 1ns / 1ps
// An accepted input transaction is held in the input register, which feeds the
// sequencer; its result lands in the output register. Throughput: one transaction
// per cycle while the output is not stalled.
// A stalled output holds both stages; ready follows the output register.
// Reset (rst_n, async, active low): idle phase, counters zero, registers at defaults.
module stepper_pulse_ramp_generator_unit
    import sprg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic [STEP_BITS-1:0]  step_count,
    input  logic [DELAY_BITS-1:0] target_delay,
    input  logic                  direction,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  dir_level,
    output logic                  step_level,
    output logic                  busy_res,
    output logic                  move_done,
    output logic                  start_ignored
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t core_result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    advance;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;

    sprg_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.kind         <= kind;
            item_reg.step_count   <= step_count;
            item_reg.target_delay <= target_delay;
            item_reg.direction    <= direction;
        end
    end

    sprg_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (in_valid_reg && advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            result_reg <= core_result;
    end

    assign out_valid     = out_valid_reg;
    assign dir_level     = result_reg.dir_level;
    assign step_level    = result_reg.step_level;
    assign busy_res      = result_reg.busy_res;
    assign move_done     = result_reg.move_done;
    assign start_ignored = result_reg.start_ignored;

    a_done_not_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(move_done && start_ignored))
        else $error("move_done and start_ignored in the same result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && move_done) |-> !busy_res)
        else $error("move finished but still busy");

    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && step_level) |-> busy_res)
        else $error("step pulse outside a move");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output register");

endmodule

### src/sprg_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the stepper pulse ramp generator.
// Depends on sprg_pkg for the register codes, reset values and cfg_t.
module sprg_cfg_regs
    import sprg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_ms   <= RST_TICKS_PER_MS;
            cfg_reg.pulse_ticks    <= RST_PULSE_TICKS;
            cfg_reg.ramp_offset_ms <= RST_RAMP_OFFSET_MS;
            cfg_reg.setup_ms       <= RST_SETUP_MS;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_TICKS_PER_MS:   cfg_reg.ticks_per_ms   <= wr_data;
                REG_PULSE_TICKS:    cfg_reg.pulse_ticks    <= wr_data;
                REG_RAMP_OFFSET_MS: cfg_reg.ramp_offset_ms <= wr_data;
                REG_SETUP_MS:       cfg_reg.setup_ms       <= wr_data;
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/sprg_core.sv
`timescale 1ns / 1ps
// Move sequencer: phase, step, delay and tick counters, and the result logic.
// Depends on sprg_pkg for item_t, cfg_t, result_t and the widths.
module sprg_core
    import sprg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SETUP = 2'd1,
        PH_PULSE = 2'd2,
        PH_WAIT  = 2'd3
    } phase_t;

    localparam logic [CUR_W-1:0] CUR_MAX = {CUR_W{1'b1}};

    phase_t                phase_reg, phase_next;
    logic [STEP_BITS-1:0]  steps_left_reg, steps_left_next;
    logic [CUR_W-1:0]      cur_delay_reg, cur_delay_next;
    logic [DELAY_BITS-1:0] final_delay_reg, final_delay_next;
    logic [CUR_W-1:0]      ms_left_reg, ms_left_next;
    logic [CFG_W-1:0]      tick_reg, tick_next;
    logic                  dir_reg, dir_next;

    logic [SUM_W-1:0] start_sum;
    logic [SUM_W-1:0] setup_ext;
    logic [CUR_W-1:0] ms_work;
    logic [CFG_W-1:0] tick_work;
    logic             done;
    logic             ignored;

    assign start_sum = SUM_W'(item.target_delay) + SUM_W'(cfg.ramp_offset_ms);
    assign setup_ext = SUM_W'(cfg.setup_ms);

    always_comb
    begin
        phase_next       = phase_reg;
        steps_left_next  = steps_left_reg;
        cur_delay_next   = cur_delay_reg;
        final_delay_next = final_delay_reg;
        ms_left_next     = ms_left_reg;
        tick_next        = tick_reg;
        dir_next         = dir_reg;
        ms_work          = ms_left_reg;
        tick_work        = tick_reg;
        done             = 1'b0;
        ignored          = 1'b0;

        if (item.kind == KIND_START)
        begin
            if (phase_reg != PH_IDLE)
            begin
                ignored = 1'b1;
            end
            else
            begin
                // saturate the ramp start delay at the counter's full scale
                if (start_sum > SUM_W'(CUR_MAX))
                    cur_delay_next = CUR_MAX;
                else
                    cur_delay_next = start_sum[CUR_W-1:0];
                dir_next         = item.direction;
                steps_left_next  = item.step_count;
                final_delay_next = item.target_delay;
                ms_left_next     = setup_ext[CUR_W-1:0];
                tick_next        = '0;
                phase_next       = PH_SETUP;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_SETUP, PH_WAIT:
                begin
                    if (ms_left_reg != '0)
                    begin
                        tick_work = tick_reg + 1'b1;
                        if (tick_work >= cfg.ticks_per_ms)
                        begin
                            tick_work = '0;
                            ms_work   = ms_left_reg - 1'b1;
                        end
                    end
                    ms_left_next = ms_work;
                    tick_next    = tick_work;
                    if (ms_work == '0)
                    begin
                        tick_next = '0;
                        if (steps_left_reg != '0)
                        begin
                            steps_left_next = steps_left_reg - 1'b1;
                            phase_next      = PH_PULSE;
                        end
                        else
                        begin
                            ms_left_next = '0;
                            phase_next   = PH_IDLE;
                            done         = 1'b1;
                        end
                    end
                end
                PH_PULSE:
                begin
                    tick_work = tick_reg + 1'b1;
                    tick_next = tick_work;
                    if (tick_work >= cfg.pulse_ticks)
                    begin
                        // lower the delay before the wait that uses it
                        if (cur_delay_reg > CUR_W'(final_delay_reg))
                        begin
                            cur_delay_next = cur_delay_reg - 1'b1;
                        end
                        ms_left_next = (cur_delay_reg > CUR_W'(final_delay_reg)) ?
                                       cur_delay_reg - 1'b1 : cur_delay_reg;
                        tick_next    = '0;
                        phase_next   = PH_WAIT;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            steps_left_reg  <= '0;
            cur_delay_reg   <= '0;
            final_delay_reg <= '0;
            ms_left_reg     <= '0;
            tick_reg        <= '0;
            dir_reg         <= 1'b0;
        end
        else if (en)
        begin
            phase_reg       <= phase_next;
            steps_left_reg  <= steps_left_next;
            cur_delay_reg   <= cur_delay_next;
            final_delay_reg <= final_delay_next;
            ms_left_reg     <= ms_left_next;
            tick_reg        <= tick_next;
            dir_reg         <= dir_next;
        end
    end

    assign result.dir_level     = dir_next;
    assign result.step_level    = (phase_next == PH_PULSE);
    assign result.busy_res      = (phase_next != PH_IDLE);
    assign result.move_done     = done;
    assign result.start_ignored = ignored;

endmodule

### test/stepper_pulse_ramp_generator_unit_test.sv
`timescale 1ns / 1ps
// Self-checking test of stepper_pulse_ramp_generator_unit: directed moves, then random moves,
// each result checked against an in-bench prediction of the step/dir pins and status flags.
// Depends on sprg_pkg and the block's RTL only.
module stepper_pulse_ramp_generator_unit_test;
    import sprg_pkg::*;

    localparam int LIMIT        = 2_000_000;
    localparam int DRAIN_CYCLES = 32;
    localparam int RANDOM_ITEMS = 400;
    localparam int RANDOM_MOVES = 15;
    localparam logic [CUR_W-1:0] CUR_MAX = '1;

    typedef enum logic [1:0] {MV_IDLE, MV_SETUP, MV_PULSE, MV_WAIT} ramp_phase_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  kind;
    logic [STEP_BITS-1:0]  step_count;
    logic [DELAY_BITS-1:0] target_delay;
    logic                  direction;
    logic                  out_valid;
    logic                  out_ready;
    logic                  dir_level;
    logic                  step_level;
    logic                  busy_res;
    logic                  move_done;
    logic                  start_ignored;

    // Predicted motion state and register copy
    cfg_t                  cfg_shadow;
    ramp_phase_t           ramp_phase;
    logic [STEP_BITS-1:0]  steps_to_go;
    logic [CUR_W-1:0]      delay_now_ms;
    logic [DELAY_BITS-1:0] delay_goal_ms;
    logic [CUR_W-1:0]      wait_ms_left;
    logic [7:0]            tick_count;
    logic                  dir_latched;

    result_t expected_pins[$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      active_items   = 0;
    int      moves_finished = 0;
    int      burst_left     = 0;
    bit      gaps_on        = 1'b1;
    bit      stall_enable   = 1'b1;
    int      hold_off_left  = 0;

    stepper_pulse_ramp_generator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .step_count    (step_count),
        .target_delay  (target_delay),
        .direction     (direction),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .dir_level     (dir_level),
        .step_level    (step_level),
        .busy_res      (busy_res),
        .move_done     (move_done),
        .start_ignored (start_ignored)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch, cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Apply one transaction to the predicted state and return the pin levels after it.
    function automatic result_t advance_stepper(input item_t it);
        result_t       r;
        logic          done;
        logic          ignored;
        logic [CUR_W:0] sum;
        done    = 1'b0;
        ignored = 1'b0;
        if (it.kind == KIND_START)
        begin
            if (ramp_phase != MV_IDLE)
            begin
                ignored = 1'b1;
            end
            else
            begin
                sum           = (CUR_W+1)'(it.target_delay) +
                                (CUR_W+1)'(cfg_shadow.ramp_offset_ms);
                delay_now_ms  = (sum > CUR_MAX) ? CUR_MAX : sum[CUR_W-1:0];
                delay_goal_ms = it.target_delay;
                dir_latched   = it.direction;
                steps_to_go   = it.step_count;
                wait_ms_left  = CUR_W'(cfg_shadow.setup_ms);
                tick_count    = '0;
                ramp_phase    = MV_SETUP;
            end
        end
        else
        begin
            case (ramp_phase)
                MV_SETUP, MV_WAIT:
                begin
                    if (wait_ms_left != 0)
                    begin
                        tick_count = tick_count + 1'b1;
                        if (tick_count >= cfg_shadow.ticks_per_ms)
                        begin
                            tick_count   = '0;
                            wait_ms_left = wait_ms_left - 1'b1;
                        end
                    end
                    // the last tick of a wait already starts the next pulse, or ends the move if no steps are left
                    if (wait_ms_left == 0)
                    begin
                        tick_count = '0;
                        if (steps_to_go != 0)
                        begin
                            steps_to_go = steps_to_go - 1'b1;
                            ramp_phase  = MV_PULSE;
                        end
                        else
                        begin
                            ramp_phase = MV_IDLE;
                            done       = 1'b1;
                        end
                    end
                end
                MV_PULSE:
                begin
                    tick_count = tick_count + 1'b1;
                    if (tick_count >= cfg_shadow.pulse_ticks)
                    begin
                        // lower the delay first, then wait the lowered value
                        if (delay_now_ms > delay_goal_ms)
                            delay_now_ms = delay_now_ms - 1'b1;
                        wait_ms_left = delay_now_ms;
                        tick_count   = '0;
                        ramp_phase   = MV_WAIT;
                    end
                end
                default: ;
            endcase
        end
        r.dir_level     = dir_latched;
        r.step_level    = (ramp_phase == MV_PULSE);
        r.busy_res      = (ramp_phase != MV_IDLE);
        r.move_done     = done;
        r.start_ignored = ignored;
        return r;
    endfunction

    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pins.size() == 0)
            begin
                report_mismatch("result with no transaction outstanding");
            end
            else
            begin
                want = expected_pins.pop_front();
                if (dir_level !== want.dir_level)
                    report_mismatch($sformatf("dir_level %b, want %b", dir_level, want.dir_level));
                if (step_level !== want.step_level)
                    report_mismatch($sformatf("step_level %b, want %b", step_level,
                                              want.step_level));
                if (busy_res !== want.busy_res)
                    report_mismatch($sformatf("busy_res %b, want %b", busy_res, want.busy_res));
                if (move_done !== want.move_done)
                    report_mismatch($sformatf("move_done %b, want %b", move_done, want.move_done));
                if (start_ignored !== want.start_ignored)
                    report_mismatch($sformatf("start_ignored %b, want %b", start_ignored,
                                              want.start_ignored));
            end
        end
    end

    // Receiver: runs of ready and stall, plus a long hold-off on request.
    initial
    begin : receiver
        int  run_left;
        bit  ready_now;
        run_left  = 0;
        ready_now = 1'b1;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                out_ready <= 1'b0;
                hold_off_left--;
            end
            else
            begin
                if (run_left == 0)
                begin
                    if (!stall_enable || $urandom_range(0, 2) != 0)
                    begin
                        ready_now = 1'b1;
                        run_left  = $urandom_range(1, 24);
                    end
                    else
                    begin
                        ready_now = 1'b0;
                        run_left  = $urandom_range(1, 8);
                    end
                end
                run_left--;
                out_ready <= ready_now;
            end
        end
    end

    task automatic send_item(input item_t it);
        int      gap;
        result_t want;
        if (gaps_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = $urandom_range(0, 5);
            if (gap != 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        if (burst_left != 0)
            burst_left--;
        @(negedge clk);
        in_valid     <= 1'b1;
        kind         <= it.kind;
        step_count   <= it.step_count;
        target_delay <= it.target_delay;
        direction    <= it.direction;
        do @(posedge clk); while (!in_ready);
        if ((it.kind == KIND_START && ramp_phase == MV_IDLE) ||
            (it.kind == KIND_TICK && ramp_phase != MV_IDLE))
            active_items++;
        want = advance_stepper(it);
        if (want.move_done)
            moves_finished++;
        expected_pins.push_back(want);
    endtask

    task automatic send_tick;
        item_t it;
        it.kind         = KIND_TICK;
        it.step_count   = STEP_BITS'($urandom_range(0, 65535));
        it.target_delay = DELAY_BITS'($urandom_range(0, 1023));
        it.direction    = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic send_start(input logic [STEP_BITS-1:0] steps,
                              input logic [DELAY_BITS-1:0] goal_ms, input logic dir);
        item_t it;
        it.kind         = KIND_START;
        it.step_count   = steps;
        it.target_delay = goal_ms;
        it.direction    = dir;
        send_item(it);
    endtask

    task automatic run_to_idle;
        while (ramp_phase != MV_IDLE)
            send_tick();
    endtask

    // Drop valid, then hold until every expected result has been seen.
    task automatic wait_all_results;
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_pins.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_TICKS_PER_MS:   cfg_shadow.ticks_per_ms   = val;
            REG_PULSE_TICKS:    cfg_shadow.pulse_ticks    = val;
            REG_RAMP_OFFSET_MS: cfg_shadow.ramp_offset_ms = val;
            REG_SETUP_MS:       cfg_shadow.setup_ms       = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_W-1:0] tpm, input logic [CFG_W-1:0] pulse,
                              input logic [CFG_W-1:0] offset, input logic [CFG_W-1:0] setup);
        wait_all_results();
        write_reg(REG_TICKS_PER_MS, tpm);
        write_reg(REG_PULSE_TICKS, pulse);
        write_reg(REG_RAMP_OFFSET_MS, offset);
        write_reg(REG_SETUP_MS, setup);
    endtask

    task automatic test_reset_defaults;
        send_tick();
        send_tick();
        send_start(16'd1, 10'd0, 1'b1);
        run_to_idle();
        send_tick();
    endtask

    task automatic test_zero_length_waits;
        set_config(8'd1, 8'd1, 8'd0, 8'd0);
        send_start(16'd3, 10'd0, 1'b0);
        run_to_idle();
        // zero steps: setup only, then done
        send_start(16'd0, 10'd0, 1'b1);
        run_to_idle();
    endtask

    task automatic test_start_while_busy;
        set_config(8'd2, 8'd2, 8'd3, 8'd1);
        send_start(16'd2, 10'd2, 1'b1);
        send_start(16'hFFFF, 10'h3FF, 1'b0);
        send_tick();
        send_start(16'h0000, 10'h000, 1'b0);
        send_tick();
        send_start(16'hA5A5, 10'h155, 1'b1);
        run_to_idle();
    endtask

    task automatic test_zero_time_base;
        set_config(8'd0, 8'd0, 8'd2, 8'd1);
        send_start(16'd2, 10'd1, 1'b0);
        run_to_idle();
    endtask

    task automatic test_register_extremes;
        set_config(8'd255, 8'd255, 8'd0, 8'd1);
        send_start(16'd1, 10'd0, 1'b1);
        run_to_idle();
        set_config(8'd1, 8'd1, 8'd255, 8'd255);
        send_start(16'd0, 10'd2, 1'b0);
        run_to_idle();
    endtask

    task automatic test_max_target;
        set_config(8'd1, 8'd1, 8'd255, 8'd2);
        send_start(16'd1, 10'd1023, 1'b0);
        run_to_idle();
    endtask

    task automatic test_longest_move;
        set_config(8'd1, 8'd1, 8'd0, 8'd0);
        gaps_on      = 1'b0;
        stall_enable = 1'b0;
        send_start(16'd100, 10'd0, 1'b1);
        run_to_idle();
        gaps_on      = 1'b1;
        stall_enable = 1'b1;
    endtask

    task automatic test_back_pressure;
        set_config(8'd1, 8'd2, 8'd4, 8'd1);
        send_start(16'd20, 10'd3, 1'b1);
        hold_off_left = 300;
        repeat (60) send_tick();
        wait_all_results();
        run_to_idle();
    endtask

    task automatic test_random_moves;
        int pick;
        int first_active;
        int first_moves;
        first_active = active_items;
        first_moves  = moves_finished;
        while ((active_items - first_active) < RANDOM_ITEMS ||
               (moves_finished - first_moves) < RANDOM_MOVES)
        begin
            set_config(CFG_W'($urandom_range(1, 2)), CFG_W'($urandom_range(1, 3)),
                       CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(0, 2)));
            gaps_on      = ($urandom_range(0, 3) != 0);
            stall_enable = ($urandom_range(0, 3) != 0);
            repeat (50)
            begin
                pick = $urandom_range(0, 99);
                if (ramp_phase == MV_IDLE)
                begin
                    if (pick < 80)
                        send_start(STEP_BITS'($urandom_range(0, 4)),
                                   DELAY_BITS'($urandom_range(0, 4)),
                                   1'($urandom_range(0, 1)));
                    else if (pick < 85)
                        send_start(STEP_BITS'($urandom_range(0, 30)),
                                   DELAY_BITS'($urandom_range(0, 12)),
                                   1'($urandom_range(0, 1)));
                    else
                        send_tick();
                end
                else if (pick < 5)
                begin
                    send_start(STEP_BITS'($urandom_range(0, 65535)),
                               DELAY_BITS'($urandom_range(0, 1023)),
                               1'($urandom_range(0, 1)));
                end
                else
                begin
                    send_tick();
                end
            end
            run_to_idle();
        end
        gaps_on      = 1'b1;
        stall_enable = 1'b1;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        kind         = KIND_TICK;
        step_count   = '0;
        target_delay = '0;
        direction    = 1'b0;

        cfg_shadow.ticks_per_ms   = RST_TICKS_PER_MS;
        cfg_shadow.pulse_ticks    = RST_PULSE_TICKS;
        cfg_shadow.ramp_offset_ms = RST_RAMP_OFFSET_MS;
        cfg_shadow.setup_ms       = RST_SETUP_MS;
        ramp_phase    = MV_IDLE;
        steps_to_go   = '0;
        delay_now_ms  = '0;
        delay_goal_ms = '0;
        wait_ms_left  = '0;
        tick_count    = '0;
        dir_latched   = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_length_waits();
        test_start_while_busy();
        test_zero_time_base();
        test_register_extremes();
        test_max_target();
        test_back_pressure();
        test_longest_move();
        test_random_moves();

        wait_all_results();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
